// ----- hdl/eig2_pkg.sv -----
// ----------------------------------------------------------------------------
// eig2_pkg
// Types, widths and lane codes shared by the 2x2 symmetric eigen solver.
// ----------------------------------------------------------------------------
package eig2_pkg;

  localparam int DATA_W   = 32;          // input element width, Q16.16
  localparam int EIG_W    = 36;          // eigenvalue width, Q20.16
  localparam int VEC_W    = 32;          // eigenvector component width, Q1.30
  localparam int THR_W    = 31;          // threshold register width
  localparam int VEC_FRAC = 30;          // fraction bits of a vector component

  localparam int DIFF_W   = DATA_W + 1;  // a-d, d-a, a+d, 2|b|
  localparam int R_W      = DATA_W + 1;  // root of the discriminant
  localparam int UMAG_W   = DATA_W + 2;  // |(d-a) +/- r|
  localparam int N_W      = DATA_W + 2;  // vector norm
  localparam int Q_W      = VEC_FRAC + 1;
  localparam int DIV_STEPS = VEC_FRAC + 1;

  localparam int LANES   = 4;
  localparam int LANE_LX = 0;
  localparam int LANE_LY = 1;
  localparam int LANE_SX = 2;
  localparam int LANE_SY = 3;

  localparam logic [VEC_W-1:0] VEC_ONE = VEC_W'(1) << VEC_FRAC;

  typedef struct packed {
    logic signed [DATA_W-1:0] diag_first;
    logic signed [DATA_W-1:0] off_diag;
    logic signed [DATA_W-1:0] diag_second;
  } eig2_in_t;

  typedef struct packed {
    logic signed [EIG_W-1:0] eig_large;
    logic signed [EIG_W-1:0] eig_small;
    logic signed [VEC_W-1:0] vec_large_x;
    logic signed [VEC_W-1:0] vec_large_y;
    logic signed [VEC_W-1:0] vec_small_x;
    logic signed [VEC_W-1:0] vec_small_y;
  } eig2_out_t;

  // carried alongside the discriminant root
  typedef struct packed {
    logic [DIFF_W-1:0] dma;
    logic [DIFF_W-1:0] trace;
    logic [DIFF_W-1:0] bb;
    logic              bneg;
    logic              vec_en;
  } eig2_rside_t;

  // carried alongside the large-vector norm
  typedef struct packed {
    logic [EIG_W-1:0]  eig_l;
    logic [EIG_W-1:0]  eig_s;
    logic [DIFF_W-1:0] bb;
    logic [UMAG_W-1:0] ul_mag;
    logic              ul_neg;
    logic              bneg;
    logic              vec_en;
  } eig2_lside_t;

  // carried alongside the small-vector norm
  typedef struct packed {
    logic [UMAG_W-1:0] us_mag;
    logic              us_neg;
  } eig2_sside_t;

  // carried through the divider
  typedef struct packed {
    logic [EIG_W-1:0] eig_l;
    logic [EIG_W-1:0] eig_s;
    logic             ul_neg;
    logic             us_neg;
    logic             bneg;
    logic             vec_en;
  } eig2_dside_t;

endpackage

// ----- hdl/symmetric_2x2_eigen_solver.sv -----
// ----------------------------------------------------------------------------
// symmetric_2x2_eigen_solver
// Closed-form eigenvalues and unit eigenvectors of a symmetric 2x2 matrix.
// ----------------------------------------------------------------------------
// Takes one matrix [[a b][b d]] in signed Q16.16 per transaction and returns
// both eigenvalues (floor((a+d+/-r)/2), r = floor(sqrt((a-d)^2+4b^2))) in a
// 36-bit Q20.16 and one unit eigenvector per eigenvalue in Q1.30, rounded
// half away from zero; the x components are never negative. When |b| is not
// above offdiag_threshold (cfg port, reset 0) the vectors are the axes (1,0)
// and (0,1). One transaction is accepted every cycle unless the pipeline
// holds. Results pass two integer square roots (33 and 34 stages, one root
// bit per stage) and the 31-stage restoring divider that normalises the
// vectors. The whole pipeline holds while the output register is full and
// stalled. Write the threshold only while no transaction is in flight.
// ----------------------------------------------------------------------------
module symmetric_2x2_eigen_solver (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  eig2_pkg::eig2_in_t        in_item,
  output logic                      out_valid,
  input  logic                      out_stall,
  output eig2_pkg::eig2_out_t       out_item,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [eig2_pkg::THR_W-1:0] cfg_data
);

  import eig2_pkg::*;

  localparam int SQ_R_W = 2 * R_W;   // discriminant radicand
  localparam int SQ_N_W = 2 * N_W;   // norm radicand
  localparam int REM_W  = N_W + 1;

  // --------------------------------------------------------------------------
  // Threshold register and global advance
  // --------------------------------------------------------------------------
  logic [THR_W-1:0] thr_r;
  logic             out_valid_r;
  eig2_out_t        out_item_r;
  logic             en;

  assign cfg_ready = 1'b1;
  assign en        = !out_valid_r || !out_stall;   // output free or leaving
  assign in_stall  = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      thr_r <= cfg_data;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 0: differences, trace, |2b|, threshold test
  // --------------------------------------------------------------------------
  logic [DATA_W-1:0] a_u, b_u, d_u, bmag;
  logic [DIFF_W-1:0] ad_nxt, admag_nxt;
  eig2_rside_t       p0_side_nxt;

  always_comb begin
    a_u       = in_item.diag_first;
    b_u       = in_item.off_diag;
    d_u       = in_item.diag_second;
    bmag      = b_u[DATA_W-1] ? (~b_u + 1'b1) : b_u;
    ad_nxt    = {a_u[DATA_W-1], a_u} - {d_u[DATA_W-1], d_u};
    admag_nxt = ad_nxt[DIFF_W-1] ? (~ad_nxt + 1'b1) : ad_nxt;
    p0_side_nxt.dma    = {d_u[DATA_W-1], d_u} - {a_u[DATA_W-1], a_u};
    p0_side_nxt.trace  = {a_u[DATA_W-1], a_u} + {d_u[DATA_W-1], d_u};
    p0_side_nxt.bb     = {bmag, 1'b0};
    p0_side_nxt.bneg   = b_u[DATA_W-1];
    p0_side_nxt.vec_en = bmag > {1'b0, thr_r};
  end

  logic              p0_valid_r, p1_valid_r, p2_valid_r;
  logic [DIFF_W-1:0] p0_admag_r;
  eig2_rside_t       p0_side_r, p1_side_r, p2_side_r;
  logic [SQ_R_W-1:0] p1_sqad_r, p1_sqb_r, p2_rad_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p0_valid_r <= 1'b0;
      p1_valid_r <= 1'b0;
      p2_valid_r <= 1'b0;
    end else if (en) begin
      p0_valid_r <= in_valid;
      p1_valid_r <= p0_valid_r;
      p2_valid_r <= p1_valid_r;
    end
  end

  // stage 1 squares, stage 2 sum
  always_ff @(posedge clk) begin
    if (en) begin
      p0_admag_r <= admag_nxt;
      p0_side_r  <= p0_side_nxt;
      p1_sqad_r  <= SQ_R_W'(p0_admag_r) * SQ_R_W'(p0_admag_r);
      p1_sqb_r   <= SQ_R_W'(p0_side_r.bb) * SQ_R_W'(p0_side_r.bb);
      p1_side_r  <= p0_side_r;
      p2_rad_r   <= p1_sqad_r + p1_sqb_r;
      p2_side_r  <= p1_side_r;
    end
  end

  // --------------------------------------------------------------------------
  // Discriminant root r
  // --------------------------------------------------------------------------
  logic           rt_valid;
  logic [R_W-1:0] rt_root;
  eig2_rside_t    rt_side;

  eig2_isqrt #(
    .ROOT_W (R_W),
    .SIDE_W ($bits(eig2_rside_t))
  ) u_root (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (p2_valid_r),
    .in_rad    (p2_rad_r),
    .in_side   (p2_side_r),
    .out_valid (rt_valid),
    .out_root  (rt_root),
    .out_side  (rt_side)
  );

  // --------------------------------------------------------------------------
  // Stage 3: eigenvalues and the U terms (d-a)+/-r
  // --------------------------------------------------------------------------
  logic [EIG_W-1:0]  sum_l, sum_s;
  logic [UMAG_W:0]   ul, us;
  logic [EIG_W-1:0]  eig_l_nxt, eig_s_nxt;
  logic [UMAG_W-1:0] ulmag_nxt, usmag_nxt;

  always_comb begin
    sum_l = {{(EIG_W-DIFF_W){rt_side.trace[DIFF_W-1]}}, rt_side.trace}
          + {{(EIG_W-R_W){1'b0}}, rt_root};
    sum_s = {{(EIG_W-DIFF_W){rt_side.trace[DIFF_W-1]}}, rt_side.trace}
          - {{(EIG_W-R_W){1'b0}}, rt_root};
    eig_l_nxt = {sum_l[EIG_W-1], sum_l[EIG_W-1:1]};   // floor halving
    eig_s_nxt = {sum_s[EIG_W-1], sum_s[EIG_W-1:1]};
    ul = {{(UMAG_W+1-DIFF_W){rt_side.dma[DIFF_W-1]}}, rt_side.dma}
       + {{(UMAG_W+1-R_W){1'b0}}, rt_root};
    us = {{(UMAG_W+1-DIFF_W){rt_side.dma[DIFF_W-1]}}, rt_side.dma}
       - {{(UMAG_W+1-R_W){1'b0}}, rt_root};
    ulmag_nxt = ul[UMAG_W] ? UMAG_W'(~ul + 1'b1) : ul[UMAG_W-1:0];
    usmag_nxt = us[UMAG_W] ? UMAG_W'(~us + 1'b1) : us[UMAG_W-1:0];
  end

  logic              p3_valid_r, p4_valid_r, p5_valid_r;
  eig2_lside_t       p3_lside_r, p4_lside_r, p5_lside_r;
  eig2_sside_t       p3_sside_r, p4_sside_r, p5_sside_r;
  logic [SQ_N_W-1:0] p4_ulsq_r, p4_ussq_r, p5_radl_r, p5_rads_r;
  logic [SQ_R_W-1:0] p4_bbsq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p3_valid_r <= 1'b0;
      p4_valid_r <= 1'b0;
      p5_valid_r <= 1'b0;
    end else if (en) begin
      p3_valid_r <= rt_valid;
      p4_valid_r <= p3_valid_r;
      p5_valid_r <= p4_valid_r;
    end
  end

  // stage 4 squares, stage 5 norm radicands
  always_ff @(posedge clk) begin
    if (en) begin
      p3_lside_r.eig_l  <= eig_l_nxt;
      p3_lside_r.eig_s  <= eig_s_nxt;
      p3_lside_r.bb     <= rt_side.bb;
      p3_lside_r.ul_mag <= ulmag_nxt;
      p3_lside_r.ul_neg <= ul[UMAG_W];
      p3_lside_r.bneg   <= rt_side.bneg;
      p3_lside_r.vec_en <= rt_side.vec_en;
      p3_sside_r.us_mag <= usmag_nxt;
      p3_sside_r.us_neg <= us[UMAG_W];
      p4_ulsq_r  <= SQ_N_W'(p3_lside_r.ul_mag) * SQ_N_W'(p3_lside_r.ul_mag);
      p4_ussq_r  <= SQ_N_W'(p3_sside_r.us_mag) * SQ_N_W'(p3_sside_r.us_mag);
      p4_bbsq_r  <= SQ_R_W'(p3_lside_r.bb) * SQ_R_W'(p3_lside_r.bb);
      p4_lside_r <= p3_lside_r;
      p4_sside_r <= p3_sside_r;
      p5_radl_r  <= p4_ulsq_r + SQ_N_W'(p4_bbsq_r);
      p5_rads_r  <= p4_ussq_r + SQ_N_W'(p4_bbsq_r);
      p5_lside_r <= p4_lside_r;
      p5_sside_r <= p4_sside_r;
    end
  end

  // --------------------------------------------------------------------------
  // Vector norms, both in lock step
  // --------------------------------------------------------------------------
  logic           nl_valid, ns_valid;
  logic [N_W-1:0] nl_root, ns_root;
  eig2_lside_t    nl_side;
  eig2_sside_t    ns_side;

  eig2_isqrt #(
    .ROOT_W (N_W),
    .SIDE_W ($bits(eig2_lside_t))
  ) u_norm_l (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (p5_valid_r),
    .in_rad    (p5_radl_r),
    .in_side   (p5_lside_r),
    .out_valid (nl_valid),
    .out_root  (nl_root),
    .out_side  (nl_side)
  );

  eig2_isqrt #(
    .ROOT_W (N_W),
    .SIDE_W ($bits(eig2_sside_t))
  ) u_norm_s (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (p5_valid_r),
    .in_rad    (p5_rads_r),
    .in_side   (p5_sside_r),
    .out_valid (ns_valid),
    .out_root  (ns_root),
    .out_side  (ns_side)
  );

  // --------------------------------------------------------------------------
  // Restoring divider: num * 2^30 / norm, one quotient bit per stage, 4 lanes.
  // num <= norm always, so the first stage decides the 2^30 bit.
  // --------------------------------------------------------------------------
  logic              dv_valid_r [DIV_STEPS];
  eig2_dside_t       dv_side_r  [DIV_STEPS];
  logic [REM_W-1:0]  dv_rem_r   [DIV_STEPS][LANES];
  logic [Q_W-1:0]    dv_q_r     [DIV_STEPS][LANES];
  logic [N_W-1:0]    dv_den_r   [DIV_STEPS][LANES];

  logic              dv_valid_in [DIV_STEPS];
  eig2_dside_t       dv_side_in  [DIV_STEPS];
  logic [REM_W-1:0]  dv_rem_in   [DIV_STEPS][LANES];
  logic [Q_W-1:0]    dv_q_in     [DIV_STEPS][LANES];
  logic [N_W-1:0]    dv_den_in   [DIV_STEPS][LANES];
  logic [REM_W:0]    dv_diff     [DIV_STEPS][LANES];
  logic [REM_W-1:0]  dv_keep     [DIV_STEPS][LANES];
  logic [REM_W-1:0]  dv_rem_nxt  [DIV_STEPS][LANES];
  logic [Q_W-1:0]    dv_q_nxt    [DIV_STEPS][LANES];

  eig2_dside_t       dv_side0;
  logic [REM_W-1:0]  dv_num0 [LANES];
  logic [N_W-1:0]    dv_den0 [LANES];

  always_comb begin
    dv_side0.eig_l  = nl_side.eig_l;
    dv_side0.eig_s  = nl_side.eig_s;
    dv_side0.ul_neg = nl_side.ul_neg;
    dv_side0.us_neg = ns_side.us_neg;
    dv_side0.bneg   = nl_side.bneg;
    dv_side0.vec_en = nl_side.vec_en;
    dv_num0[LANE_LX] = REM_W'(nl_side.bb);
    dv_num0[LANE_LY] = REM_W'(nl_side.ul_mag);
    dv_num0[LANE_SX] = REM_W'(nl_side.bb);
    dv_num0[LANE_SY] = REM_W'(ns_side.us_mag);
    dv_den0[LANE_LX] = nl_root;
    dv_den0[LANE_LY] = nl_root;
    dv_den0[LANE_SX] = ns_root;
    dv_den0[LANE_SY] = ns_root;
  end

  genvar j, l;
  for (j = 0; j < DIV_STEPS; j++) begin : g_div
    if (j == 0) begin : g_first
      assign dv_valid_in[j] = nl_valid;
      assign dv_side_in[j]  = dv_side0;
    end else begin : g_next
      assign dv_valid_in[j] = dv_valid_r[j-1];
      assign dv_side_in[j]  = dv_side_r[j-1];
    end
    for (l = 0; l < LANES; l++) begin : g_lane
      if (j == 0) begin : g_first
        assign dv_rem_in[j][l] = dv_num0[l];
        assign dv_q_in[j][l]   = '0;
        assign dv_den_in[j][l] = dv_den0[l];
      end else begin : g_next
        assign dv_rem_in[j][l] = dv_rem_r[j-1][l];
        assign dv_q_in[j][l]   = dv_q_r[j-1][l];
        assign dv_den_in[j][l] = dv_den_r[j-1][l];
      end
      assign dv_diff[j][l]  = {1'b0, dv_rem_in[j][l]} - {2'b00, dv_den_in[j][l]};
      assign dv_keep[j][l]  = dv_diff[j][l][REM_W] ? dv_rem_in[j][l]
                                                   : dv_diff[j][l][REM_W-1:0];
      assign dv_q_nxt[j][l] = {dv_q_in[j][l][Q_W-2:0], ~dv_diff[j][l][REM_W]};
      if (j < DIV_STEPS - 1) begin : g_shift
        assign dv_rem_nxt[j][l] = {dv_keep[j][l][REM_W-2:0], 1'b0};
      end else begin : g_last
        assign dv_rem_nxt[j][l] = dv_keep[j][l];   // kept for rounding
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < DIV_STEPS; k++) dv_valid_r[k] <= 1'b0;
    end else if (en) begin
      for (int k = 0; k < DIV_STEPS; k++) dv_valid_r[k] <= dv_valid_in[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < DIV_STEPS; k++) begin
        dv_side_r[k] <= dv_side_in[k];
        for (int m = 0; m < LANES; m++) begin
          dv_rem_r[k][m] <= dv_rem_nxt[k][m];
          dv_q_r[k][m]   <= dv_q_nxt[k][m];
          dv_den_r[k][m] <= dv_den_in[k][m];
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output stage: round half up on magnitude, apply signs, pick axes
  // --------------------------------------------------------------------------
  logic [Q_W-1:0]   q_rnd [LANES];
  logic [VEC_W-1:0] vmag  [LANES];
  eig2_dside_t      fin_side;
  eig2_out_t        out_item_nxt;

  always_comb begin
    fin_side = dv_side_r[DIV_STEPS-1];
    for (int m = 0; m < LANES; m++) begin
      q_rnd[m] = dv_q_r[DIV_STEPS-1][m]
               + Q_W'({dv_rem_r[DIV_STEPS-1][m][N_W-1:0], 1'b0}
                      >= {1'b0, dv_den_r[DIV_STEPS-1][m]});
      vmag[m]  = VEC_W'(q_rnd[m]);
    end
    out_item_nxt.eig_large = fin_side.eig_l;
    out_item_nxt.eig_small = fin_side.eig_s;
    if (fin_side.vec_en) begin
      out_item_nxt.vec_large_x = vmag[LANE_LX];
      out_item_nxt.vec_large_y = (fin_side.ul_neg != fin_side.bneg)
                               ? (~vmag[LANE_LY] + 1'b1) : vmag[LANE_LY];
      out_item_nxt.vec_small_x = vmag[LANE_SX];
      out_item_nxt.vec_small_y = (fin_side.us_neg != fin_side.bneg)
                               ? (~vmag[LANE_SY] + 1'b1) : vmag[LANE_SY];
    end else begin
      out_item_nxt.vec_large_x = VEC_ONE;
      out_item_nxt.vec_large_y = '0;
      out_item_nxt.vec_small_x = '0;
      out_item_nxt.vec_small_y = VEC_ONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv_valid_r[DIV_STEPS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

`ifndef SYNTH
  // both norm roots must run in lock step
  a_norm_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    nl_valid == ns_valid)
    else $error("norm pipelines out of step");

  a_eig_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_item_r.eig_large >= out_item_r.eig_small)
    else $error("eigenvalues out of order");

  a_x_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !out_item_r.vec_large_x[VEC_W-1] && !out_item_r.vec_small_x[VEC_W-1])
    else $error("negative x component");

  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(p0_valid_r) && $stable(dv_valid_r[DIV_STEPS-1]))
    else $error("pipeline moved while held");
`endif

endmodule

// ----- hdl/eig2_isqrt.sv -----
// ----------------------------------------------------------------------------
// eig2_isqrt
// Pipelined integer square root, one root bit per stage, with a sideband
// that travels in step with the radicand.
// ----------------------------------------------------------------------------
module eig2_isqrt #(
  parameter int ROOT_W = 33,
  parameter int SIDE_W = 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic [2*ROOT_W-1:0]   in_rad,
  input  logic [SIDE_W-1:0]     in_side,
  output logic                  out_valid,
  output logic [ROOT_W-1:0]     out_root,
  output logic [SIDE_W-1:0]     out_side
);

  localparam int RAD_W = 2 * ROOT_W;
  localparam int REM_W = ROOT_W + 2;

  logic              vld_r    [ROOT_W];
  logic [RAD_W-1:0]  rad_r    [ROOT_W];
  logic [REM_W-1:0]  rem_r    [ROOT_W];
  logic [ROOT_W-1:0] root_r   [ROOT_W];
  logic [SIDE_W-1:0] side_r   [ROOT_W];

  logic              vld_in   [ROOT_W];
  logic [RAD_W-1:0]  rad_in   [ROOT_W];
  logic [REM_W-1:0]  rem_in   [ROOT_W];
  logic [ROOT_W-1:0] root_in  [ROOT_W];
  logic [SIDE_W-1:0] side_in  [ROOT_W];

  logic [REM_W-1:0]  rem_sh   [ROOT_W];
  logic [REM_W-1:0]  trial    [ROOT_W];
  logic [REM_W:0]    diff     [ROOT_W];
  logic [RAD_W-1:0]  rad_nxt  [ROOT_W];
  logic [REM_W-1:0]  rem_nxt  [ROOT_W];
  logic [ROOT_W-1:0] root_nxt [ROOT_W];

  genvar i;
  for (i = 0; i < ROOT_W; i++) begin : g_step
    if (i == 0) begin : g_first
      assign vld_in[i]  = in_valid;
      assign rad_in[i]  = in_rad;
      assign rem_in[i]  = '0;
      assign root_in[i] = '0;
      assign side_in[i] = in_side;
    end else begin : g_next
      assign vld_in[i]  = vld_r[i-1];
      assign rad_in[i]  = rad_r[i-1];
      assign rem_in[i]  = rem_r[i-1];
      assign root_in[i] = root_r[i-1];
      assign side_in[i] = side_r[i-1];
    end

    // bring down two radicand bits, try root*4+1
    assign rem_sh[i]   = {rem_in[i][ROOT_W-1:0], rad_in[i][RAD_W-1 -: 2]};
    assign trial[i]    = {root_in[i], 2'b01};
    assign diff[i]     = {1'b0, rem_sh[i]} - {1'b0, trial[i]};
    assign rad_nxt[i]  = {rad_in[i][RAD_W-3:0], 2'b00};
    assign rem_nxt[i]  = diff[i][REM_W] ? rem_sh[i] : diff[i][REM_W-1:0];
    assign root_nxt[i] = {root_in[i][ROOT_W-2:0], ~diff[i][REM_W]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < ROOT_W; k++) vld_r[k] <= 1'b0;
    end else if (en) begin
      for (int k = 0; k < ROOT_W; k++) vld_r[k] <= vld_in[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < ROOT_W; k++) begin
        rad_r[k]  <= rad_nxt[k];
        rem_r[k]  <= rem_nxt[k];
        root_r[k] <= root_nxt[k];
        side_r[k] <= side_in[k];
      end
    end
  end

  assign out_valid = vld_r[ROOT_W-1];
  assign out_root  = root_r[ROOT_W-1];
  assign out_side  = side_r[ROOT_W-1];

endmodule

// ----- test/tb_symmetric_2x2_eigen_solver.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_symmetric_2x2_eigen_solver
// Self-checking bench for the closed-form 2x2 symmetric eigen solver.
// ----------------------------------------------------------------------------
// A behavioural model of the eigen solver predicts each result from the
// matrix sent. Expected results wait in a queue. A checker process compares
// every result leaving the block with the oldest one waiting. Stimulus runs
// in named phases: directed corners, random matrices under several threshold
// settings, a long output hold-off, and a drain pause.
// ----------------------------------------------------------------------------
module tb_symmetric_2x2_eigen_solver;
  import eig2_pkg::*;

  localparam int LATENCY     = 105;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [THR_W-1:0] THR_MAX = '1;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  eig2_in_t  in_item;
  logic      out_valid;
  logic      out_stall;
  eig2_out_t out_item;
  logic      cfg_valid;
  logic      cfg_ready;
  logic [THR_W-1:0] cfg_data;

  // model copy of the threshold register
  logic [THR_W-1:0] thr_model;
  eig2_out_t        eig_expected_q[$];
  int               mismatch_cnt;
  int               matrices_sent;
  int               results_seen;
  longint           cycle_cnt;
  bit               hold_request;   // output hold-off asked for
  int               hold_len;
  bit               quiet_sink;     // no random output stalls

  symmetric_2x2_eigen_solver u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Model arithmetic, all on wide unsigned vectors
  // --------------------------------------------------------------------------
  // floor(sqrt(x^2 + y^2)), bit by bit
  function automatic logic [63:0] hypot_root(logic [63:0] x, logic [63:0] y);
    logic [129:0] sum;
    logic [63:0]  root;
    logic [63:0]  trial;
    sum  = 130'(x) * 130'(x) + 130'(y) * 130'(y);
    root = '0;
    for (int i = 63; i >= 0; i--) begin
      trial = root | (64'd1 << i);
      if (130'(trial) * 130'(trial) <= sum) root = trial;
    end
    return root;
  endfunction

  // round(num * 2^30 / den), half away from zero
  function automatic logic [63:0] norm_div(logic [63:0] num, logic [63:0] den);
    logic [95:0] scaled;
    logic [95:0] quo;
    logic [95:0] rem;
    scaled = 96'(num) << VEC_FRAC;
    quo    = scaled / den;
    rem    = scaled % den;
    if (rem >= 96'(den) - rem) quo++;
    return quo[63:0];
  endfunction

  // one unit vector: (B, sign(b) * U) / |(B, U)|
  function automatic void unit_vector(input logic [63:0] bmag2, input logic bneg,
                                      input logic signed [63:0] u,
                                      output logic [VEC_W-1:0] vx,
                                      output logic [VEC_W-1:0] vy);
    logic [63:0] umag;
    logic [63:0] nrm;
    logic [63:0] qy;
    umag = (u < 0) ? -u : u;
    nrm  = hypot_root(bmag2, umag);
    if (nrm == 0) nrm = 1;
    vx = VEC_W'(norm_div(bmag2, nrm));
    qy = norm_div(umag, nrm);
    vy = VEC_W'(((u < 0) != bneg) ? -qy : qy);
  endfunction

  function automatic eig2_out_t predict_eigen(eig2_in_t m);
    logic signed [63:0] a, b, d;
    logic [63:0]        bmag, trace, dma, diff_mag, root, hi, lo;
    logic [VEC_W-1:0]   lx, ly, sx, sy;
    eig2_out_t          res;
    a        = 64'(m.diag_first);
    b        = 64'(m.off_diag);
    d        = 64'(m.diag_second);
    bmag     = (b < 0) ? -b : b;
    trace    = a + d;
    dma      = d - a;
    diff_mag = (a - d < 0) ? d - a : a - d;
    root     = hypot_root(diff_mag, bmag << 1);
    hi       = trace + root;
    lo       = trace - root;
    // floor halving keeps the sign
    res.eig_large = EIG_W'({hi[63], hi[63:1]});
    res.eig_small = EIG_W'({lo[63], lo[63:1]});
    if (bmag > 64'(thr_model)) begin
      unit_vector(bmag << 1, b < 0, dma + root, lx, ly);
      unit_vector(bmag << 1, b < 0, dma - root, sx, sy);
    end else begin
      lx = VEC_ONE; ly = '0;
      sx = '0;      sy = VEC_ONE;
    end
    res.vec_large_x = lx;
    res.vec_large_y = ly;
    res.vec_small_x = sx;
    res.vec_small_y = sy;
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Mismatch reporting
  // --------------------------------------------------------------------------
  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    mismatch_cnt++;
    $display("MISMATCH @%0t %s: got %0h expected %0h", $realtime, what, got, want);
  endtask

  // --------------------------------------------------------------------------
  // Result checker
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (eig_expected_q.size() == 0) begin
        report_mismatch("unexpected transaction", 64'(out_item), '0);
      end else begin
        eig2_out_t want;
        want = eig_expected_q.pop_front();
        if (out_item.eig_large !== want.eig_large)
          report_mismatch("eig_large", 64'(out_item.eig_large), 64'(want.eig_large));
        if (out_item.eig_small !== want.eig_small)
          report_mismatch("eig_small", 64'(out_item.eig_small), 64'(want.eig_small));
        if (out_item.vec_large_x !== want.vec_large_x)
          report_mismatch("vec_large_x", 64'(out_item.vec_large_x),
                          64'(want.vec_large_x));
        if (out_item.vec_large_y !== want.vec_large_y)
          report_mismatch("vec_large_y", 64'(out_item.vec_large_y),
                          64'(want.vec_large_y));
        if (out_item.vec_small_x !== want.vec_small_x)
          report_mismatch("vec_small_x", 64'(out_item.vec_small_x),
                          64'(want.vec_small_x));
        if (out_item.vec_small_y !== want.vec_small_y)
          report_mismatch("vec_small_y", 64'(out_item.vec_small_y),
                          64'(want.vec_small_y));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver back-pressure: random stalls, plus a long hold-off on request
  // --------------------------------------------------------------------------
  initial begin
    int burst;
    out_stall = 1'b1;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_request) begin
        out_stall <= 1'b1;
        repeat (hold_len) @(posedge clk);
        hold_request = 1'b0;
      end else if (quiet_sink || $urandom_range(0, 3) != 0) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        burst = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                            : $urandom_range(1, 3);
        out_stall <= 1'b1;
        repeat (burst) @(posedge clk);
      end
    end
  end

  // cycle watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_cnt);
      $display("Verification failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Shared stimulus tasks
  // --------------------------------------------------------------------------
  // one transaction on the input side, then an optional random gap
  task automatic send_matrix(eig2_in_t m, bit gaps);
    int gap;
    in_item  <= m;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    eig_expected_q.push_back(predict_eigen(m));
    matrices_sent++;
    if (gaps && $urandom_range(0, 2) == 0) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30)
                                        : $urandom_range(1, 3);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic go_idle();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // wait for the pipe to empty, then let it settle
  task automatic drain_pipe();
    in_valid <= 1'b0;
    while (eig_expected_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  task automatic write_threshold(logic [THR_W-1:0] thr);
    cfg_data  <= thr;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    thr_model = thr;
    @(posedge clk);
  endtask

  function automatic logic [DATA_W-1:0] rand_elem();
    case ($urandom_range(0, 5))
      0:       return DATA_W'($urandom_range(0, 65535)) - 32768;  // near zero
      1:       return {1'b1, 31'($urandom)};                     // negative
      2:       return {1'b0, 31'($urandom)};                     // positive
      3:       return DATA_W'($urandom_range(0, 7)) - 4;
      default: return DATA_W'($urandom);
    endcase
  endfunction

  function automatic eig2_in_t rand_matrix();
    eig2_in_t m;
    m.diag_first  = rand_elem();
    m.off_diag    = rand_elem();
    m.diag_second = ($urandom_range(0, 7) == 0) ? m.diag_first : rand_elem();
    return m;
  endfunction

  function automatic eig2_in_t mk(logic [DATA_W-1:0] a, logic [DATA_W-1:0] b,
                                  logic [DATA_W-1:0] d);
    eig2_in_t m;
    m.diag_first = a; m.off_diag = b; m.diag_second = d;
    return m;
  endfunction

  // --------------------------------------------------------------------------
  // Test tasks
  // --------------------------------------------------------------------------
  task automatic test_directed_corners();
    logic [DATA_W-1:0] mn, mx;
    mn = {1'b1, {(DATA_W-1){1'b0}}};
    mx = {1'b0, {(DATA_W-1){1'b1}}};
    send_matrix(mk(0, 0, 0), 0);                 // zero matrix
    send_matrix(mk(32'h10000, 0, 32'h20000), 0); // diagonal, zero off-diagonal
    send_matrix(mk(32'h10000, 1, 32'h10000), 0); // smallest b, equal diagonal
    send_matrix(mk(32'h10000, -1, 32'h10000), 0);
    send_matrix(mk(mx, mx, mx), 0);              // all extremes
    send_matrix(mk(mn, mn, mn), 0);
    send_matrix(mk(mx, mn, mn), 0);
    send_matrix(mk(mn, mx, mx), 0);
    send_matrix(mk(mn, 0, mx), 0);
    send_matrix(mk(mx, 0, mn), 0);
    send_matrix(mk(mx, mx, mn), 0);
    send_matrix(mk(mn, mn, mx), 0);
    send_matrix(mk(0, mx, 0), 0);
    send_matrix(mk(0, mn, 0), 0);
    send_matrix(mk(-1, -1, -1), 0);
    send_matrix(mk(32'h30000, 32'h10000, 32'h30000), 0);
    send_matrix(mk(32'hFFFF0000, 32'h8000, 32'h10000), 0);
    go_idle();
    drain_pipe();
    // threshold boundary: |b| equal to and just above the register
    write_threshold(31'h10000);
    send_matrix(mk(32'h20000, 32'h10000, 32'h10000), 0);
    send_matrix(mk(32'h20000, 32'hFFFF0000, 32'h10000), 0);
    send_matrix(mk(32'h20000, 32'h10001, 32'h10000), 0);
    send_matrix(mk(32'h20000, 32'hFFFEFFFF, 32'h10000), 0);
    go_idle();
    drain_pipe();
    write_threshold(THR_MAX);
    send_matrix(mk(0, mn, 0), 0);                // only |b| = 2^31 beats it
    send_matrix(mk(0, mx, 0), 0);
    go_idle();
    drain_pipe();
  endtask

  task automatic test_random_thresholds();
    logic [THR_W-1:0] thr_set[5];
    thr_set = '{'0, 31'h100, 31'h10000, 31'h3FFFFFFF, THR_MAX};
    foreach (thr_set[i]) begin
      write_threshold(thr_set[i]);
      quiet_sink = (i == 2);   // one phase at full rate on both sides
      repeat (160) send_matrix(rand_matrix(), i != 2);
      go_idle();
      drain_pipe();
    end
    quiet_sink = 1'b0;
  endtask

  // output held off while the sender keeps offering, so the pipe fills
  task automatic test_output_hold();
    write_threshold(THR_W'($urandom_range(0, 65535)));
    hold_len     = 3 * LATENCY;
    hold_request = 1'b1;
    repeat (150) send_matrix(rand_matrix(), 0);
    go_idle();
    drain_pipe();
  endtask

  // sender pauses until every expected result is back, between bursts
  task automatic test_drain_pause();
    write_threshold('0);
    repeat (5) begin
      repeat (30) send_matrix(rand_matrix(), 1);
      go_idle();
      while (eig_expected_q.size() != 0) @(posedge clk);
    end
    drain_pipe();
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_item      = '0;
    cfg_valid    = 1'b0;
    cfg_data     = '0;
    thr_model    = '0;
    mismatch_cnt = 0;
    matrices_sent = 0;
    results_seen = 0;
    cycle_cnt    = 0;
    hold_request = 1'b0;
    hold_len     = 0;
    quiet_sink   = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_corners();
    test_random_thresholds();
    test_output_hold();
    test_drain_pause();

    $display("Sent %0d matrices, checked %0d results over five threshold settings,",
             matrices_sent, results_seen);
    $display("with a long output hold-off and drain pauses; %0d mismatches.",
             mismatch_cnt);
    if (mismatch_cnt == 0 && eig_expected_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      if (eig_expected_q.size() != 0)
        $display("%0d expected transactions never arrived", eig_expected_q.size());
      $display("Verification failed");
    end
    $finish;
  end

endmodule
